@@ rtl/cdg_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the
// chunk descriptor generator. No dependencies.
package cdg_pkg;

	// Offset table geometry
	localparam int MAX_SEQ     = 256;
	localparam int TABLE_DEPTH = MAX_SEQ + 1;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int LOAD_W      = $clog2(TABLE_DEPTH + 1);
	localparam int SEQ_W       = $clog2(MAX_SEQ);

	// Field widths
	localparam int OFS_W      = 32;
	localparam int IDX_W      = 32;
	localparam int CS_W       = 17;
	localparam int CNT_W      = 16;
	localparam int OSEQ_W     = 8;
	localparam int STAT_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = (IDX_W - 1) + CS_W;

	// Register reset values
	localparam logic [CS_W-1:0]  CHUNK_SIZE_RST = CS_W'(64);
	localparam logic [CNT_W-1:0] TOTAL_RST      = CNT_W'(1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_EXPL = 2'd1,
		ACT_AUTO = 2'd2,
		ACT_FIN  = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_SEQ   = 3'd1,
		ST_BAD_CHUNK = 3'd2,
		ST_MISMATCH  = 3'd3,
		ST_SHORT     = 3'd4,
		ST_EXHAUSTED = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	// Which result the datapath builds on a commit
	typedef enum logic [2:0] {
		SEL_LOAD  = 3'd0,
		SEL_SHORT = 3'd1,
		SEL_EXPL  = 3'd2,
		SEL_AUTO  = 3'd3,
		SEL_FIN   = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic     take;
		logic     mul;
		logic     auto_run;
		logic     commit;
		res_sel_t sel;
	} cdg_cmd_t;

	typedef struct packed {
		logic loaded_lt2;
		logic hit;
		logic can_adv;
		logic out_free;
	} cdg_stat_t;

endpackage

@@ rtl/cdg_req_if.sv @@
// Input item channel: valid/ready plus the request payload.
// Depends on cdg_pkg.
interface cdg_req_if import cdg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              action;
	logic [OFS_W-1:0]        offset_value;
	logic signed [IDX_W-1:0] seq_index;
	logic signed [IDX_W-1:0] local_chunk;

	modport source (output valid, action, offset_value, seq_index, local_chunk, input ready);
	modport sink   (input valid, action, offset_value, seq_index, local_chunk, output ready);
endinterface

@@ rtl/cdg_rsp_if.sv @@
// Result channel: valid/ready plus the descriptor and status payload.
// Depends on cdg_pkg.
interface cdg_rsp_if import cdg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OSEQ_W-1:0] out_sequence;
	logic [OFS_W-1:0]  chunk_begin;
	logic [OFS_W-1:0]  chunk_end;
	logic [CNT_W-1:0]  out_local_chunk;
	logic [CNT_W-1:0]  emitted_count;
	logic [STAT_W-1:0] status;

	modport source (output valid, out_sequence, chunk_begin, chunk_end, out_local_chunk,
		emitted_count, status, input ready);
	modport sink   (input valid, out_sequence, chunk_begin, chunk_end, out_local_chunk,
		emitted_count, status, output ready);
endinterface

@@ rtl/cdg_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on cdg_pkg.
interface cdg_cfg_if import cdg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/cdg_ctrl.sv @@
// Controller state machine: sequences one request beat through the datapath.
// Depends on cdg_pkg.
module cdg_ctrl import cdg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  logic [1:0] req_action,
	input  cdg_stat_t stat,
	output cdg_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOAD  = 7'b0000010,
		S_SHORT = 7'b0000100,
		S_FIN   = 7'b0001000,
		S_XMUL  = 7'b0010000,
		S_XCHK  = 7'b0100000,
		S_AUTO  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Decode next state and datapath commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.sel   = SEL_LOAD;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					if (action_t'(req_action) == ACT_LOAD) begin
						state_d = S_LOAD;
					end else if (stat.loaded_lt2) begin
						state_d = S_SHORT;
					end else begin
						case (action_t'(req_action))
							ACT_EXPL: state_d = S_XMUL;
							ACT_AUTO: state_d = S_AUTO;
							default:  state_d = S_FIN;
						endcase
					end
				end
			end
			S_LOAD: begin
				cmd.sel = SEL_LOAD;
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SHORT: begin
				cmd.sel = SEL_SHORT;
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FIN: begin
				cmd.sel = SEL_FIN;
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_XMUL: begin
				cmd.mul = 1'b1;
				state_d = S_XCHK;
			end
			S_XCHK: begin
				cmd.sel = SEL_EXPL;
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_AUTO: begin
				// step over empty sequences until a chunk is found or the table ends
				cmd.auto_run = 1'b1;
				cmd.sel      = SEL_AUTO;
				if ((stat.hit || !stat.can_adv) && stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/cdg_dp.sv @@
// Datapath: offset table memory, cursor, counters, multiply/clip logic and
// the result register. Depends on cdg_pkg.
module cdg_dp import cdg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cdg_cmd_t                cmd,
	output cdg_stat_t               stat,
	input  logic [1:0]              in_action,
	input  logic [OFS_W-1:0]        in_offset,
	input  logic [IDX_W-1:0]        in_seq_index,
	input  logic [IDX_W-1:0]        in_local_chunk,
	input  logic                    cfg_valid,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [OSEQ_W-1:0]       out_sequence,
	output logic [OFS_W-1:0]        out_begin,
	output logic [OFS_W-1:0]        out_end,
	output logic [CNT_W-1:0]        out_local_chunk,
	output logic [CNT_W-1:0]        out_count,
	output logic [STAT_W-1:0]       out_status
);

	// Configuration registers
	logic [CS_W-1:0]  cs_q;
	logic [CNT_W-1:0] total_q;
	logic [CS_W-1:0]  cs_eff;

	// Table and its registered read ports
	logic [OFS_W-1:0]  tbl_mem [TABLE_DEPTH];
	logic [OFS_W-1:0]  rd_a_q, rd_b_q;
	logic [ADDR_W-1:0] addr_a, addr_b;

	// Control state
	logic [LOAD_W-1:0] loaded_q;
	logic [SEQ_W-1:0]  cseq_q;
	logic [OFS_W-1:0]  cbeg_q;
	logic [CNT_W-1:0]  cchk_q;
	logic              started_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_inc;

	// Captured request
	logic [OFS_W-1:0] ofs_q;
	logic [IDX_W-1:0] sidx_q;
	logic [IDX_W-1:0] craw_q;

	// Explicit path pipeline
	logic [PROD_W-1:0] prod_s1;
	logic [OFS_W-1:0]  len_s1, st_s1, en_s1, stcs_s1;
	logic              bad_seq, bad_chunk, x_fit;
	logic [PROD_W:0]   x_pc;
	logic [OFS_W-1:0]  x_b, x_e;

	// Automatic cursor view
	logic [SEQ_W-1:0] cur_seq_e;
	logic [OFS_W-1:0] cur_beg_e;
	logic [CNT_W-1:0] cur_chk_e;
	logic [OFS_W-1:0] a_diff, a_e;
	logic             hit, can_adv, adv, tbl_full;

	// Result
	logic              out_valid_q;
	logic [OSEQ_W-1:0] r_seq;
	logic [OFS_W-1:0]  r_b, r_e;
	logic [CNT_W-1:0]  r_lc, r_cnt;
	status_t           r_st;
	logic              r_emit;

	assign cs_eff   = (cs_q == '0) ? CS_W'(1) : cs_q;
	assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
	assign tbl_full = (loaded_q == LOAD_W'(TABLE_DEPTH));

	// Cursor as seen by the walk: first use starts at sequence 0, entry 0
	assign cur_seq_e = started_q ? cseq_q : '0;
	assign cur_beg_e = started_q ? cbeg_q : rd_a_q;
	assign cur_chk_e = started_q ? cchk_q : '0;
	assign hit       = (cur_beg_e < rd_b_q);
	assign can_adv   = (LOAD_W'(cur_seq_e) + LOAD_W'(2)) < loaded_q;
	assign adv       = cmd.auto_run && !hit && can_adv;
	assign a_diff    = rd_b_q - cur_beg_e;
	assign a_e       = (OFS_W'(cs_eff) < a_diff) ? cur_beg_e + OFS_W'(cs_eff) : rd_b_q;

	assign stat.loaded_lt2 = (loaded_q < LOAD_W'(2));
	assign stat.hit        = hit;
	assign stat.can_adv    = can_adv;
	assign stat.out_free   = !out_valid_q || out_ready;

	// Select table read addresses
	always_comb begin
		if (cmd.take) begin
			if (action_t'(in_action) == ACT_AUTO) begin
				addr_a = '0;
				addr_b = started_q ? ADDR_W'(cseq_q) + ADDR_W'(1) : ADDR_W'(1);
			end else begin
				addr_a = in_seq_index[ADDR_W-1:0];
				addr_b = in_seq_index[ADDR_W-1:0] + ADDR_W'(1);
			end
		end else if (cmd.auto_run) begin
			addr_a = '0;
			addr_b = ADDR_W'(cur_seq_e) + (adv ? ADDR_W'(2) : ADDR_W'(1));
		end else begin
			addr_a = sidx_q[ADDR_W-1:0];
			addr_b = sidx_q[ADDR_W-1:0] + ADDR_W'(1);
		end
	end

	// Table write on load, two registered reads
	always_ff @(posedge clk) begin
		if (cmd.commit && cmd.sel == SEL_LOAD && !tbl_full) begin
			tbl_mem[loaded_q[ADDR_W-1:0]] <= ofs_q;
		end
		rd_a_q <= tbl_mem[addr_a];
		rd_b_q <= tbl_mem[addr_b];
	end

	// Explicit request checks and chunk bounds
	assign bad_seq = sidx_q[IDX_W-1] || (sidx_q[IDX_W-2:ADDR_W] != '0) ||
		(({1'b0, sidx_q[ADDR_W-1:0]} + (ADDR_W+1)'(1)) >= (ADDR_W+1)'(loaded_q));
	assign x_pc      = {1'b0, prod_s1} + (PROD_W+1)'(cs_eff);
	assign bad_chunk = craw_q[IDX_W-1] || (prod_s1 >= PROD_W'(len_s1));
	assign x_fit     = x_pc < (PROD_W+1)'(len_s1);
	assign x_b       = st_s1 + prod_s1[OFS_W-1:0];
	assign x_e       = x_fit ? stcs_s1 + prod_s1[OFS_W-1:0] : en_s1;

	// Capture request and multiply stage
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ofs_q  <= in_offset;
			sidx_q <= in_seq_index;
			craw_q <= in_local_chunk;
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(craw_q[IDX_W-2:0]) * PROD_W'(cs_eff);
			len_s1  <= (rd_b_q > rd_a_q) ? rd_b_q - rd_a_q : '0;
			st_s1   <= rd_a_q;
			en_s1   <= rd_b_q;
			stcs_s1 <= rd_a_q + OFS_W'(cs_eff);
		end
	end

	// Build the result beat
	always_comb begin
		r_seq  = '0;
		r_b    = '0;
		r_e    = '0;
		r_lc   = '0;
		r_cnt  = cnt_q;
		r_st   = ST_OK;
		r_emit = 1'b0;
		case (cmd.sel)
			SEL_LOAD: begin
				if (tbl_full) begin
					r_st = ST_FULL;
				end
			end
			SEL_SHORT: r_st = ST_SHORT;
			SEL_EXPL: begin
				if (bad_seq) begin
					r_st = ST_BAD_SEQ;
				end else if (bad_chunk) begin
					r_st = ST_BAD_CHUNK;
				end else begin
					r_emit = 1'b1;
					r_seq  = sidx_q[OSEQ_W-1:0];
					r_b    = x_b;
					r_e    = x_e;
					r_lc   = craw_q[CNT_W-1:0];
					r_cnt  = cnt_inc;
				end
			end
			SEL_AUTO: begin
				if (hit) begin
					r_emit = 1'b1;
					r_seq  = OSEQ_W'(cur_seq_e);
					r_b    = cur_beg_e;
					r_e    = a_e;
					r_lc   = cur_chk_e;
					r_cnt  = cnt_inc;
				end else begin
					r_st = ST_EXHAUSTED;
				end
			end
			SEL_FIN: begin
				r_st = (total_q != '0 && cnt_q == total_q) ? ST_OK : ST_MISMATCH;
			end
			default: r_st = ST_OK;
		endcase
	end

	// Configuration, table fill, cursor and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q      <= CHUNK_SIZE_RST;
			total_q   <= TOTAL_RST;
			loaded_q  <= '0;
			cseq_q    <= '0;
			cbeg_q    <= '0;
			cchk_q    <= '0;
			started_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_CHUNK_SIZE) begin
					cs_q <= cfg_data[CS_W-1:0];
				end else if (cfg_index == REG_TOTAL) begin
					total_q <= cfg_data[CNT_W-1:0];
				end
			end
			if (cmd.commit && cmd.sel == SEL_LOAD && !tbl_full) begin
				loaded_q <= loaded_q + LOAD_W'(1);
			end
			if (cmd.commit && r_emit) begin
				cnt_q <= cnt_inc;
			end
			// walk: emit advances within the sequence, a miss moves to the next one
			if (cmd.auto_run) begin
				started_q <= 1'b1;
				if (hit && cmd.commit) begin
					cseq_q <= cur_seq_e;
					cbeg_q <= a_e;
					cchk_q <= cur_chk_e + CNT_W'(1);
				end else if (!hit && can_adv) begin
					cseq_q <= cur_seq_e + SEQ_W'(1);
					cbeg_q <= rd_b_q;
					cchk_q <= '0;
				end else begin
					cseq_q <= cur_seq_e;
					cbeg_q <= cur_beg_e;
					cchk_q <= cur_chk_e;
				end
			end
			if (cmd.commit && cmd.sel == SEL_FIN) begin
				cnt_q     <= '0;
				started_q <= 1'b0;
				cseq_q    <= '0;
				cbeg_q    <= '0;
				cchk_q    <= '0;
			end
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_sequence    <= r_seq;
			out_begin       <= r_b;
			out_end         <= r_e;
			out_local_chunk <= r_lc;
			out_count       <= r_cnt;
			out_status      <= r_st;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/chunk_descriptor_generator.sv @@
// Top level of the chunk descriptor generator: controller plus datapath.
// Depends on cdg_pkg, cdg_ctrl, cdg_dp and the three channel interfaces.

// One request beat is handled at a time; results leave through a one-deep
// output register, so a new request is taken while the last result waits.
// Steps per beat: load offset, finish and short-table errors are captured and
// committed; an explicit chunk takes a table read, a 31x17 multiply, then the
// range check and clip; an automatic step walks the table, stepping over empty
// or used-up sequences, one table read each. A stalled result
// adds its wait. Configuration writes are always accepted (ready is tied
// high) and must only arrive while the block is idle. The offset table holds
// 257 entries; loads beyond that are dropped with status table full.
module chunk_descriptor_generator import cdg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cdg_cfg_if.sink    cfg,
	cdg_req_if.sink    req,
	cdg_rsp_if.source  rsp
);

	cdg_cmd_t  cmd;
	cdg_stat_t stat;

	assign cfg.ready = 1'b1;

	cdg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_action (req.action),
		.stat       (stat),
		.cmd        (cmd)
	);

	cdg_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_action       (req.action),
		.in_offset       (req.offset_value),
		.in_seq_index    (req.seq_index),
		.in_local_chunk  (req.local_chunk),
		.cfg_valid       (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_sequence    (rsp.out_sequence),
		.out_begin       (rsp.chunk_begin),
		.out_end         (rsp.chunk_end),
		.out_local_chunk (rsp.out_local_chunk),
		.out_count       (rsp.emitted_count),
		.out_status      (rsp.status)
	);

endmodule

@@ rtl/cdg_checker.sv @@
// Port-level assertions for the chunk descriptor generator and their bind.
// Depends on cdg_pkg and chunk_descriptor_generator.
module cdg_checker import cdg_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [OSEQ_W-1:0] out_sequence,
	input logic [OFS_W-1:0]  chunk_begin,
	input logic [OFS_W-1:0]  chunk_end,
	input logic [CNT_W-1:0]  out_local_chunk,
	input logic [CNT_W-1:0]  emitted_count,
	input logic [STAT_W-1:0] status
);

	// One beat in flight: ready drops right after an accepted request
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// Error results carry no descriptor
	a_err_no_desc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> out_sequence == '0 && chunk_begin == '0 &&
		chunk_end == '0 && out_local_chunk == '0)
		else $error("error result carries descriptor fields");

	// A descriptor never ends before it begins
	a_end_after_begin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && chunk_end != chunk_begin |-> chunk_end > chunk_begin)
		else $error("chunk end below chunk begin");

	// Stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(chunk_begin) &&
		$stable(chunk_end) && $stable(status) && $stable(emitted_count))
		else $error("result changed while stalled");

endmodule

bind chunk_descriptor_generator cdg_checker u_cdg_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.out_sequence    (rsp.out_sequence),
	.chunk_begin     (rsp.chunk_begin),
	.chunk_end       (rsp.chunk_end),
	.out_local_chunk (rsp.out_local_chunk),
	.emitted_count   (rsp.emitted_count),
	.status          (rsp.status)
);

@@ tb/descriptor_checker.sv @@
// Result checker for the chunk descriptor generator: watches the config,
// request and result channels, predicts every result beat and compares it.
// Depends on cdg_pkg and the three channel interfaces.
module descriptor_checker import cdg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cdg_cfg_if   cfg,
	cdg_req_if   req,
	cdg_rsp_if   rsp,
	output int   mismatch_count,
	output int   awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [OSEQ_W-1:0] seq;
		logic [OFS_W-1:0]  begin_tok;
		logic [OFS_W-1:0]  end_tok;
		logic [CNT_W-1:0]  chunk;
		logic [CNT_W-1:0]  count;
		status_t           status;
	} descriptor_t;

	// Mirror of the offset table, the walking cursor and the registers
	logic [OFS_W-1:0] ofs_mem [TABLE_DEPTH];
	int unsigned      n_ofs;
	int unsigned      walk_seq;
	longint unsigned  walk_begin;
	logic [CNT_W-1:0] walk_chunk;
	bit               walk_live;
	logic [CNT_W-1:0] desc_count;
	logic [CS_W-1:0]  chunk_reg;
	logic [CNT_W-1:0] total_reg;
	descriptor_t      due_q [$];
	int               fail_count;

	task automatic report(string what);
		fail_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Clip a chunk starting at b to the sequence end e (b < e)
	function automatic longint unsigned chunk_stop(longint unsigned b, longint unsigned e);
		longint unsigned cs;
		cs = (chunk_reg == '0) ? 64'd1 : {47'd0, chunk_reg};
		return (cs < e - b) ? b + cs : e;
	endfunction

	function automatic void bump_count();
		if (desc_count != '1)
			desc_count++;
	endfunction

	// Work out the result of one request beat and advance the mirrored state
	function automatic descriptor_t predict_beat(logic [1:0] act, logic [OFS_W-1:0] ofs,
			logic [IDX_W-1:0] sidx, logic [IDX_W-1:0] lch);
		descriptor_t     d;
		longint unsigned st;
		longint unsigned en;
		longint unsigned len;
		longint unsigned prod;
		longint unsigned b;
		longint unsigned e;
		longint unsigned cs;
		bit              found;
		bit              stop;
		d = '0;
		d.status = ST_OK;
		cs = (chunk_reg == '0) ? 64'd1 : {47'd0, chunk_reg};
		if (act == ACT_LOAD) begin
			if (n_ofs < TABLE_DEPTH) begin
				ofs_mem[n_ofs] = ofs;
				n_ofs++;
			end else begin
				d.status = ST_FULL;
			end
		end else if (n_ofs < 2) begin
			d.status = ST_SHORT;
		end else if (act == ACT_EXPL) begin
			if (sidx[IDX_W-1] || {32'd0, sidx} + 64'd1 >= n_ofs) begin
				d.status = ST_BAD_SEQ;
			end else if (lch[IDX_W-1]) begin
				d.status = ST_BAD_CHUNK;
			end else begin
				st = ofs_mem[sidx];
				en = ofs_mem[sidx + 1];
				len = (en > st) ? en - st : 64'd0;
				prod = {32'd0, lch} * cs;
				if (prod >= len) begin
					d.status = ST_BAD_CHUNK;
				end else begin
					b = st + prod;
					e = chunk_stop(b, en);
					d.seq = sidx[OSEQ_W-1:0];
					d.begin_tok = b[OFS_W-1:0];
					d.end_tok = e[OFS_W-1:0];
					d.chunk = lch[CNT_W-1:0];
					bump_count();
				end
			end
		end else if (act == ACT_AUTO) begin
			if (!walk_live) begin
				walk_live = 1'b1;
				walk_seq = 0;
				walk_chunk = '0;
				walk_begin = ofs_mem[0];
			end
			found = 1'b0;
			stop = 1'b0;
			// Skip empty and used-up sequences until a chunk is left
			while (!stop && walk_seq + 1 < n_ofs) begin
				en = ofs_mem[walk_seq + 1];
				if (walk_begin < en) begin
					e = chunk_stop(walk_begin, en);
					d.seq = walk_seq[OSEQ_W-1:0];
					d.begin_tok = walk_begin[OFS_W-1:0];
					d.end_tok = e[OFS_W-1:0];
					d.chunk = walk_chunk;
					bump_count();
					walk_begin = e;
					walk_chunk++;
					found = 1'b1;
					stop = 1'b1;
				end else if (walk_seq + 2 < n_ofs) begin
					walk_seq++;
					walk_chunk = '0;
					walk_begin = ofs_mem[walk_seq];
				end else begin
					stop = 1'b1;
				end
			end
			if (!found)
				d.status = ST_EXHAUSTED;
		end else begin
			// Finish: show the count, then clear it and the cursor
			d.status = (total_reg != '0 && desc_count == total_reg) ? ST_OK : ST_MISMATCH;
			d.count = desc_count;
			desc_count = '0;
			walk_live = 1'b0;
			walk_seq = 0;
			walk_begin = 0;
			walk_chunk = '0;
			return d;
		end
		d.count = desc_count;
		return d;
	endfunction

	task automatic check_result(descriptor_t want);
		if (rsp.out_sequence !== want.seq)
			report($sformatf("out_sequence %0d, expected %0d", rsp.out_sequence, want.seq));
		if (rsp.chunk_begin !== want.begin_tok)
			report($sformatf("chunk_begin %h, expected %h", rsp.chunk_begin, want.begin_tok));
		if (rsp.chunk_end !== want.end_tok)
			report($sformatf("chunk_end %h, expected %h", rsp.chunk_end, want.end_tok));
		if (rsp.out_local_chunk !== want.chunk)
			report($sformatf("out_local_chunk %0d, expected %0d", rsp.out_local_chunk,
				want.chunk));
		if (rsp.emitted_count !== want.count)
			report($sformatf("emitted_count %0d, expected %0d", rsp.emitted_count, want.count));
		if (rsp.status !== want.status)
			report($sformatf("status %0d, expected %0d", rsp.status, want.status));
	endtask

	// Follow every beat on the three channels
	always @(posedge clk or negedge arst_n) begin : watch
		descriptor_t want;
		if (!arst_n) begin
			n_ofs = 0;
			walk_seq = 0;
			walk_begin = 0;
			walk_chunk = '0;
			walk_live = 1'b0;
			desc_count = '0;
			chunk_reg = CHUNK_SIZE_RST;
			total_reg = TOTAL_RST;
			due_q.delete();
			fail_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_CHUNK_SIZE: chunk_reg = cfg.data[CS_W-1:0];
					REG_TOTAL:      total_reg = cfg.data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				due_q.push_back(predict_beat(req.action, req.offset_value, req.seq_index,
					req.local_chunk));
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					want = due_q.pop_front();
					check_result(want);
				end
			end
		end
		mismatch_count <= fail_count;
		awaiting <= due_q.size();
	end

endmodule

@@ tb/testbench.sv @@
// Top of the chunk descriptor generator testbench: clock, reset, stimulus,
// result-side stalls, watchdog and verdict. Depends on cdg_pkg, the channel
// interfaces, chunk_descriptor_generator and descriptor_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cdg_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 300;
	localparam int GAP_MAX     = 18;
	localparam int PHASES      = 7;

	logic        clk;
	logic        arst_n;
	int          mismatch_count;
	int          awaiting;
	int          quiet_cycles;
	int          req_gap_max;
	int          rsp_gap_max;
	bit          hold_pending;
	logic [OFS_W-1:0] ofs_copy [TABLE_DEPTH];
	int unsigned n_loaded;
	int unsigned level;
	int unsigned cur_step;

	// Per-phase register settings and beat counts
	logic [31:0] chunk_plan [PHASES] = '{32'd1, 32'd0, 32'h0001_0000, 32'h0001_FFFF,
		32'hFFFE_0040, 32'd0, 32'd0};
	logic [31:0] total_plan [PHASES] = '{32'd3, 32'd0, 32'd5, 32'd65535, 32'hABCD_000C,
		32'd7, 32'd1};
	int items_plan [PHASES] = '{150, 150, 250, 150, 250, 250, 300};

	cdg_cfg_if cfg_ch();
	cdg_req_if req_ch();
	cdg_rsp_if rsp_ch();

	chunk_descriptor_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	descriptor_checker check_descriptors (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_ch),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.awaiting       (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stall the result side; take one long hold when asked
	initial begin : result_sink
		int wait_cycles;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			wait_cycles = $urandom_range(rsp_gap_max, 0);
			if (hold_pending) begin
				hold_pending = 1'b0;
				wait_cycles = LONG_HOLD;
			end
			if (wait_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Offer one request beat after a random gap and hold it until taken
	task automatic send_item(action_t act, logic [OFS_W-1:0] ofs, logic [IDX_W-1:0] sidx,
			logic [IDX_W-1:0] lch);
		int gap;
		gap = $urandom_range(req_gap_max, 0);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.offset_value <= ofs;
		req_ch.seq_index <= sidx;
		req_ch.local_chunk <= lch;
		do @(posedge clk); while (!req_ch.ready);
		if (act == ACT_LOAD && n_loaded < TABLE_DEPTH) begin
			ofs_copy[n_loaded] = ofs;
			n_loaded++;
		end
	endtask

	// Drop valid and wait until every result is back
	task automatic drain_block();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both registers back to back while the block is idle
	task automatic configure(logic [31:0] chunk_data, logic [31:0] total_data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_CHUNK_SIZE;
		cfg_ch.data <= chunk_data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= REG_TOTAL;
		cfg_ch.data <= total_data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_step = (chunk_data[CS_W-1:0] == '0) ? 1 : chunk_data[CS_W-1:0];
	endtask

	// Next cumulative offset: mostly rising, sometimes flat or falling
	function automatic logic [OFS_W-1:0] next_offset();
		if ($urandom_range(9, 0) == 0)
			level = $urandom_range(level, 0);
		else
			level = level + $urandom_range(400, 0);
		return level;
	endfunction

	// Pick a sequence and a chunk inside it; force a non-empty one if asked
	task automatic pick_chunk(bit must_hit, output logic [IDX_W-1:0] sidx,
			output logic [IDX_W-1:0] lch);
		int unsigned s;
		int unsigned len;
		int tries;
		tries = 0;
		s = $urandom_range(n_loaded - 2, 0);
		while (must_hit && ofs_copy[s + 1] <= ofs_copy[s] && tries < 16) begin
			s = $urandom_range(n_loaded - 2, 0);
			tries++;
		end
		if (must_hit && ofs_copy[s + 1] <= ofs_copy[s])
			s = 0;
		sidx = s;
		if (ofs_copy[s + 1] > ofs_copy[s]) begin
			len = ofs_copy[s + 1] - ofs_copy[s];
			lch = $urandom_range((len - 1) / cur_step, 0);
		end else begin
			lch = $urandom_range(3, 0);
		end
	endtask

	task automatic explicit_item();
		logic [IDX_W-1:0] sidx;
		logic [IDX_W-1:0] lch;
		int roll;
		roll = $urandom_range(9, 0);
		case (roll)
			7: begin
				sidx = $urandom() | 32'h8000_0000;
				lch = $urandom();
			end
			8: begin
				sidx = ($urandom_range(1, 0) == 0) ? n_loaded - 1 + $urandom_range(2, 0) :
					$urandom() & 32'h7FFF_FFFF;
				lch = $urandom_range(3, 0);
			end
			9: begin
				pick_chunk(1'b0, sidx, lch);
				lch = $urandom();
			end
			default: pick_chunk(1'b0, sidx, lch);
		endcase
		send_item(ACT_EXPL, $urandom(), sidx, lch);
	endtask

	task automatic random_item();
		int pick;
		int load_share;
		pick = $urandom_range(99, 0);
		load_share = (n_loaded >= TABLE_DEPTH) ? 8 : 25;
		if (pick < load_share)
			send_item(ACT_LOAD, (n_loaded >= TABLE_DEPTH) ? $urandom() : next_offset(),
				$urandom(), $urandom());
		else if (pick < 63)
			explicit_item();
		else if (pick < 97)
			send_item(ACT_AUTO, $urandom(), $urandom(), $urandom());
		else
			send_item(ACT_FIN, $urandom(), $urandom(), $urandom());
	endtask

	// Clear the count, emit exactly k good descriptors, then finish
	task automatic counted_run(int k);
		logic [IDX_W-1:0] sidx;
		logic [IDX_W-1:0] lch;
		send_item(ACT_FIN, $urandom(), $urandom(), $urandom());
		repeat (k) begin
			pick_chunk(1'b1, sidx, lch);
			send_item(ACT_EXPL, $urandom(), sidx, lch);
		end
		send_item(ACT_FIN, $urandom(), $urandom(), $urandom());
	endtask

	initial begin : stimulus
		int ph;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_LOAD;
		req_ch.offset_value <= '0;
		req_ch.seq_index <= '0;
		req_ch.local_chunk <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_CHUNK_SIZE;
		cfg_ch.data <= '0;
		req_gap_max = GAP_MAX;
		rsp_gap_max = GAP_MAX;
		hold_pending = 1'b0;
		n_loaded = 0;
		cur_step = CHUNK_SIZE_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Short table: every non-load action is refused
		send_item(ACT_FIN, 32'd0, 32'd0, 32'd0);
		send_item(ACT_EXPL, 32'd0, 32'd0, 32'd0);
		send_item(ACT_AUTO, 32'd0, 32'd0, 32'd0);
		send_item(ACT_LOAD, 32'hFFFF_FF00, 32'd0, 32'd0);
		send_item(ACT_AUTO, 32'd0, 32'd0, 32'd0);
		// One sequence at the top of the range, last chunk clipped
		send_item(ACT_LOAD, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_item(ACT_EXPL, 32'd0, 32'd0, 32'd3);
		send_item(ACT_FIN, 32'd0, 32'd0, 32'd0);
		// Falling, flat, normal and falling entries
		send_item(ACT_LOAD, 32'd0, 32'd0, 32'd0);
		send_item(ACT_LOAD, 32'd0, 32'd0, 32'd0);
		send_item(ACT_LOAD, 32'd130, 32'd0, 32'd0);
		send_item(ACT_LOAD, 32'd100, 32'd0, 32'd0);
		// Explicit checks
		send_item(ACT_EXPL, 32'd0, 32'h8000_0000, 32'd0);
		send_item(ACT_EXPL, 32'd0, 32'h7FFF_FFFF, 32'd0);
		send_item(ACT_EXPL, 32'd0, 32'd5, 32'd0);
		send_item(ACT_EXPL, 32'd0, 32'd3, 32'hFFFF_FFFF);
		send_item(ACT_EXPL, 32'd0, 32'd3, 32'h7FFF_FFFF);
		send_item(ACT_EXPL, 32'd0, 32'd1, 32'd0);
		send_item(ACT_EXPL, 32'd0, 32'd2, 32'd0);
		send_item(ACT_EXPL, 32'd0, 32'd3, 32'd2);
		// Walk every chunk, skip the empty ones, run out on the last
		repeat (8) send_item(ACT_AUTO, 32'd0, 32'd0, 32'd0);
		send_item(ACT_FIN, 32'd0, 32'd0, 32'd0);
		level = 100;

		for (ph = 0; ph < PHASES; ph++) begin
			drain_block();
			if (ph == 5)
				chunk_plan[ph] = $urandom_range(500, 2);
			if (ph == 6)
				chunk_plan[ph] = $urandom_range(2000, 1);
			configure(chunk_plan[ph], total_plan[ph]);
			req_gap_max = (ph % 3 == 1) ? 0 : GAP_MAX;
			rsp_gap_max = (ph % 3 == 0) ? 0 : GAP_MAX;
			if (total_plan[ph][CNT_W-1:0] <= 20)
				counted_run(total_plan[ph][CNT_W-1:0]);
			// Hold the result side off while requests keep coming
			if (ph == 1)
				hold_pending = 1'b1;
			repeat (items_plan[ph]) random_item();
		end

		drain_block();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaiting == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

@@ chunk_descriptor_generator.f @@
rtl/cdg_pkg.sv
rtl/cdg_req_if.sv
rtl/cdg_rsp_if.sv
rtl/cdg_cfg_if.sv
rtl/cdg_ctrl.sv
rtl/cdg_dp.sv
rtl/chunk_descriptor_generator.sv
rtl/cdg_checker.sv
tb/descriptor_checker.sv
tb/testbench.sv
